>>> sv/pss_pkg.sv
package pss_pkg;

    // Data set limits and accumulator widths
    localparam int MAX_SAMPLES = 4096;
    localparam int W_CNT       = $clog2(MAX_SAMPLES + 1);
    localparam int W_SX        = 16 + W_CNT;
    localparam int W_SXX       = 30 + W_CNT;
    localparam int W_SXY       = 31 + W_CNT;

    // Closing arithmetic widths
    localparam int W_WIDE  = 128;
    localparam int W_QUO   = 64;
    localparam int W_VAL   = 48;
    localparam int W_SHIFT = 6;
    localparam int W_STEP  = 8;

    localparam logic [W_CNT-1:0]   CNT_MAX    = W_CNT'(MAX_SAMPLES);
    localparam logic [W_QUO-1:0]   POS_LIMIT  = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [W_QUO-1:0]   NEG_LIMIT  = 64'h0000_8000_0000_0000;
    localparam logic [W_SHIFT-1:0] FRAC_Q16   = 6'd16;
    localparam logic [W_SHIFT-1:0] FRAC_Q32   = 6'd32;
    localparam logic [W_STEP-1:0]  MUL_STEPS  = W_STEP'(W_QUO);
    localparam logic [W_STEP-1:0]  SQRT_STEPS = W_STEP'(W_QUO / 2);
    localparam logic [W_STEP-1:0]  DIV_BASE   = W_STEP'(W_WIDE);
    localparam logic [W_WIDE-1:0]  SQRT_TOP   = W_WIDE'(1) << (W_QUO - 2);

    typedef enum logic [2:0] {
        K_MEAN_X, K_MEAN_Y, K_SD_X, K_SD_Y, K_CORR, K_SLOPE, K_INTERCEPT
    } t_kind;

    typedef enum logic [1:0] {ST_OK, ST_UNDEF, ST_FEW, ST_SAT} t_status;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic               last_pair;
    } t_pair;

    typedef struct packed {
        t_kind                    stat_kind;
        logic signed [W_VAL-1:0]  stat_value;
        t_status                  stat_status;
        logic                     last_result;
    } t_result;

    typedef struct packed {
        logic [W_CNT-1:0]        cnt;
        logic signed [W_SX-1:0]  sx;
        logic signed [W_SX-1:0]  sy;
        logic [W_SXX-1:0]        sxx;
        logic [W_SXX-1:0]        syy;
        logic signed [W_SXY-1:0] sxy;
    } t_sums;

    // Shared arithmetic unit
    typedef enum logic [2:0] {UO_MUL, UO_DIV, UO_SQRT, UO_ADD, UO_DIFF} t_uop;
    typedef enum logic [2:0] {US_IDLE, US_MUL, US_DIV, US_SQRT, US_ADD, US_DIFF} t_ustate;

    typedef struct packed {
        logic               go;
        t_uop               op;
        logic [W_WIDE-1:0]  a;
        logic [W_WIDE-1:0]  b;
        logic [W_SHIFT-1:0] k;
    } t_ucmd;

    typedef struct packed {
        logic              done;
        logic              big;
        logic              neg;
        logic [W_WIDE-1:0] res;
    } t_ursp;

    // Closing sequencer
    typedef enum logic [4:0] {
        SS_IDLE, SS_FEW, SS_NSXX, SS_SXSX, SS_DXX, SS_NSYY, SS_SYSY, SS_DYY,
        SS_NSXY, SS_SXSY, SS_DXY, SS_NN1, SS_MX, SS_MY, SS_VX, SS_SDX, SS_VY,
        SS_SDY, SS_RCHK, SS_DXY2, SS_DXXYY, SS_R2, SS_R, SS_LCHK, SS_LUND,
        SS_SL, SS_IA, SS_IB, SS_INUM, SS_NDXX, SS_IC
    } t_sstate;

    // Build one result word: clamp to Q31.16 and apply sign
    function automatic t_result pss_put(input t_kind kind, input logic neg,
                                        input logic [W_QUO-1:0] mag, input logic big,
                                        input t_status status);
        t_result          r;
        logic [W_QUO-1:0] lim;
        logic [W_QUO-1:0] m;
        t_status          st;
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        m   = mag;
        st  = status;
        r.stat_value = '0;
        if (status == ST_OK) begin
            if (big || (mag > lim)) begin
                m  = lim;
                st = ST_SAT;
            end
            r.stat_value = neg ? W_VAL'(~m + 64'd1) : W_VAL'(m);
        end
        r.stat_kind   = kind;
        r.stat_status = st;
        r.last_result = (kind == K_INTERCEPT);
        return r;
    endfunction

endpackage

>>> sv/pss_accum.sv
module pss_accum
    import pss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_pair i_pair,
    input  logic  i_clear,
    output t_sums o_sums,
    output logic  o_pend,
    output logic  o_close
);

    logic                    r_pend, r_close, r_last;
    logic signed [15:0]      r_x, r_y;
    t_sums                   r_sums, n_sums;
    logic signed [31:0]      pxx, pyy, pxy;

    // Products and running sums
    always_comb begin
        pxx    = r_x * r_x;
        pyy    = r_y * r_y;
        pxy    = r_x * r_y;
        n_sums = r_sums;
        if (i_clear) begin
            n_sums = '0;
        end else if (r_pend && (r_sums.cnt < CNT_MAX)) begin
            n_sums.cnt = r_sums.cnt + 1'b1;
            n_sums.sx  = r_sums.sx + W_SX'(r_x);
            n_sums.sy  = r_sums.sy + W_SX'(r_y);
            n_sums.sxx = r_sums.sxx + W_SXX'($unsigned(pxx));
            n_sums.syy = r_sums.syy + W_SXX'($unsigned(pyy));
            n_sums.sxy = r_sums.sxy + W_SXY'(pxy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_close <= 1'b0;
            r_sums  <= '0;
        end else begin
            r_pend  <= i_take;
            r_close <= r_pend & r_last;
            r_sums  <= n_sums;
        end
    end

    // Pair capture
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_x    <= i_pair.x_sample;
            r_y    <= i_pair.y_sample;
            r_last <= i_pair.last_pair;
        end
    end

    assign o_sums  = r_sums;
    assign o_pend  = r_pend;
    assign o_close = r_close;

    a_close_after_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_close |-> $past(r_pend))
        else $error("close without a pending word");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sums.cnt <= CNT_MAX)
        else $error("pair count above limit");
    a_no_take_in_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_take)
        else $error("word taken while accumulating");

endmodule

>>> sv/pss_unit.sv
module pss_unit
    import pss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ucmd i_cmd,
    output t_ursp o_rsp
);

    t_ustate            r_state, n_state;
    logic [W_WIDE-1:0]  r_acc, n_acc, r_a, n_a, r_b, n_b, r_res, n_res;
    logic [W_QUO-1:0]   r_q, n_q, sq_t;
    logic [W_STEP-1:0]  r_cnt, n_cnt;
    logic               r_done, n_done, r_big, n_big, r_neg, n_neg;
    logic [W_WIDE-1:0]  add_x, add_y, remsh;
    logic               add_sub;
    logic [W_WIDE:0]    sum;
    logic               carry, last_step;

    // Single shared adder / subtractor; carry out means no borrow
    assign sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                 + (W_WIDE + 1)'(add_sub);
    assign carry = sum[W_WIDE];

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_a       = r_a;
        n_b       = r_b;
        n_q       = r_q;
        n_cnt     = r_cnt;
        n_res     = r_res;
        n_big     = r_big;
        n_neg     = r_neg;
        n_done    = 1'b0;
        add_x     = r_a;
        add_y     = r_b;
        add_sub   = 1'b0;
        remsh     = {r_acc[W_WIDE-2:0], r_a[W_WIDE-1]};
        sq_t      = r_q | r_a[W_QUO-1:0];
        last_step = (r_cnt == W_STEP'(1));
        case (r_state)
            US_IDLE: begin
                if (i_cmd.go) begin
                    n_a   = i_cmd.a;
                    n_b   = i_cmd.b;
                    n_acc = '0;
                    n_q   = '0;
                    n_big = 1'b0;
                    n_neg = 1'b0;
                    n_cnt = MUL_STEPS;
                    case (i_cmd.op)
                        UO_MUL:  n_state = US_MUL;
                        UO_DIV: begin
                            n_state = US_DIV;
                            n_cnt   = DIV_BASE + W_STEP'(i_cmd.k);
                        end
                        UO_SQRT: begin
                            n_state = US_SQRT;
                            n_acc   = W_WIDE'(i_cmd.a[W_QUO-1:0]);
                            n_a     = SQRT_TOP;
                            n_cnt   = SQRT_STEPS;
                        end
                        UO_ADD:  n_state = US_ADD;
                        UO_DIFF: n_state = US_DIFF;
                        default: n_state = US_IDLE;
                    endcase
                end
            end
            // Shift-add multiply, multiplier MSB first
            US_MUL: begin
                add_x = r_acc << 1;
                add_y = r_a[W_QUO-1] ? r_b : '0;
                n_acc = sum[W_WIDE-1:0];
                n_a   = r_a << 1;
                n_cnt = r_cnt - 1'b1;
                if (last_step) begin
                    n_res   = sum[W_WIDE-1:0];
                    n_done  = 1'b1;
                    n_state = US_IDLE;
                end
            end
            // Restoring divide, one quotient bit a cycle
            US_DIV: begin
                add_x   = remsh;
                add_y   = r_b;
                add_sub = 1'b1;
                n_acc   = carry ? sum[W_WIDE-1:0] : remsh;
                n_big   = r_big | r_q[W_QUO-1] | r_q[W_QUO-2];
                n_q     = {r_q[W_QUO-2:0], carry};
                n_a     = r_a << 1;
                n_cnt   = r_cnt - 1'b1;
                if (last_step) begin
                    n_res   = W_WIDE'(n_q);
                    n_done  = 1'b1;
                    n_state = US_IDLE;
                end
            end
            // Bit-pair square root; root and bit never overlap
            US_SQRT: begin
                add_x   = r_acc;
                add_y   = W_WIDE'(sq_t);
                add_sub = 1'b1;
                if (carry) begin
                    n_acc = sum[W_WIDE-1:0];
                    n_q   = (r_q >> 1) | r_a[W_QUO-1:0];
                end else begin
                    n_q   = r_q >> 1;
                end
                n_a   = r_a >> 2;
                n_cnt = r_cnt - 1'b1;
                if (last_step) begin
                    n_res   = W_WIDE'(n_q);
                    n_done  = 1'b1;
                    n_state = US_IDLE;
                end
            end
            US_ADD: begin
                n_res   = sum[W_WIDE-1:0];
                n_done  = 1'b1;
                n_state = US_IDLE;
            end
            // Magnitude of a difference; swap once when a < b
            US_DIFF: begin
                add_sub = 1'b1;
                if (carry) begin
                    n_res   = sum[W_WIDE-1:0];
                    n_done  = 1'b1;
                    n_state = US_IDLE;
                end else begin
                    n_a   = r_b;
                    n_b   = r_a;
                    n_neg = 1'b1;
                end
            end
            default: n_state = US_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= US_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_res <= n_res;
        r_big <= n_big;
        r_neg <= n_neg;
    end

    assign o_rsp = '{done: r_done, big: r_big, neg: r_neg, res: r_res};

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for two cycles");
    a_go_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |-> (r_state == US_IDLE))
        else $error("command issued while unit busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == US_IDLE))
        else $error("done while unit still running");

endmodule

>>> sv/pss_seq.sv
module pss_seq
    import pss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_close,
    input  t_sums   i_sums,
    input  t_ursp   i_rsp,
    output t_ucmd   o_cmd,
    output logic    o_clear,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    t_sstate           r_state, n_state;
    logic              r_wait, n_wait;
    t_kind             r_kind, n_kind;
    logic [W_WIDE-1:0] r_t1, n_t1, r_t2, n_t2, r_nn1, n_nn1;
    logic [W_WIDE-1:0] r_dxx, n_dxx, r_dyy, n_dyy, r_dxy, n_dxy;
    logic              r_dneg, n_dneg, r_sn, n_sn, r_vbig, n_vbig;
    logic              r_dxxz, n_dxxz, r_dyyz, n_dyyz;
    logic              r_valid, n_valid;
    t_result           r_out, n_out;
    logic              use_unit;
    logic              nx, ny, sxyn, s2, sb;
    logic [W_SX-1:0]   ax, ay;
    logic [W_SXY-1:0]  axy;
    logic [W_QUO-1:0]  q;
    logic              rz;

    // Magnitudes and signs of the sums
    always_comb begin
        nx   = i_sums.sx[W_SX-1];
        ny   = i_sums.sy[W_SX-1];
        sxyn = i_sums.sxy[W_SXY-1];
        ax   = nx ? W_SX'(-i_sums.sx) : W_SX'(i_sums.sx);
        ay   = ny ? W_SX'(-i_sums.sy) : W_SX'(i_sums.sy);
        axy  = sxyn ? W_SXY'(-i_sums.sxy) : W_SXY'(i_sums.sxy);
        s2   = nx ^ ny;
        sb   = nx ^ r_dneg;
        q    = i_rsp.res[W_QUO-1:0];
        rz   = (i_rsp.res == '0);
    end

    // Closing sequence: at most one unit operation per step
    always_comb begin
        n_state  = r_state;
        n_wait   = r_wait;
        n_kind   = r_kind;
        n_t1     = r_t1;
        n_t2     = r_t2;
        n_nn1    = r_nn1;
        n_dxx    = r_dxx;
        n_dyy    = r_dyy;
        n_dxy    = r_dxy;
        n_dneg   = r_dneg;
        n_sn     = r_sn;
        n_vbig   = r_vbig;
        n_dxxz   = r_dxxz;
        n_dyyz   = r_dyyz;
        n_valid  = 1'b0;
        n_out    = r_out;
        use_unit = 1'b0;
        o_clear  = 1'b0;
        o_cmd    = '{go: 1'b0, op: UO_ADD, a: '0, b: '0, k: '0};
        case (r_state)
            SS_IDLE: begin
                if (i_close) begin
                    n_kind  = K_MEAN_X;
                    n_state = (i_sums.cnt < W_CNT'(2)) ? SS_FEW : SS_NSXX;
                end
            end
            SS_FEW: begin
                n_valid = 1'b1;
                n_out   = pss_put(r_kind, 1'b0, '0, 1'b0, ST_FEW);
                if (r_kind == K_INTERCEPT) begin
                    o_clear = 1'b1;
                    n_state = SS_IDLE;
                end else begin
                    n_kind = t_kind'(r_kind + 3'd1);
                end
            end
            SS_NSXX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(i_sums.cnt);
                o_cmd.b  = W_WIDE'(i_sums.sxx);
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_state = SS_SXSX;
                end
            end
            SS_SXSX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(ax);
                o_cmd.b  = W_WIDE'(ax);
                if (i_rsp.done) begin
                    n_t2    = i_rsp.res;
                    n_state = SS_DXX;
                end
            end
            SS_DXX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIFF;
                o_cmd.a  = r_t1;
                o_cmd.b  = r_t2;
                if (i_rsp.done) begin
                    n_dxx   = i_rsp.res;
                    n_dxxz  = rz;
                    n_state = SS_NSYY;
                end
            end
            SS_NSYY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(i_sums.cnt);
                o_cmd.b  = W_WIDE'(i_sums.syy);
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_state = SS_SYSY;
                end
            end
            SS_SYSY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(ay);
                o_cmd.b  = W_WIDE'(ay);
                if (i_rsp.done) begin
                    n_t2    = i_rsp.res;
                    n_state = SS_DYY;
                end
            end
            SS_DYY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIFF;
                o_cmd.a  = r_t1;
                o_cmd.b  = r_t2;
                if (i_rsp.done) begin
                    n_dyy   = i_rsp.res;
                    n_dyyz  = rz;
                    n_state = SS_NSXY;
                end
            end
            SS_NSXY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(i_sums.cnt);
                o_cmd.b  = W_WIDE'(axy);
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_state = SS_SXSY;
                end
            end
            SS_SXSY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(ax);
                o_cmd.b  = W_WIDE'(ay);
                if (i_rsp.done) begin
                    n_t2    = i_rsp.res;
                    n_state = SS_DXY;
                end
            end
            // Signed cross term from two signed products
            SS_DXY: begin
                use_unit = 1'b1;
                o_cmd.op = (sxyn != s2) ? UO_ADD : UO_DIFF;
                o_cmd.a  = r_t1;
                o_cmd.b  = r_t2;
                if (i_rsp.done) begin
                    n_dxy   = i_rsp.res;
                    n_dneg  = !rz && ((sxyn != s2) ? sxyn : (sxyn ^ i_rsp.neg));
                    n_state = SS_NN1;
                end
            end
            SS_NN1: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(i_sums.cnt);
                o_cmd.b  = W_WIDE'(i_sums.cnt - 1'b1);
                if (i_rsp.done) begin
                    n_nn1   = i_rsp.res;
                    n_state = SS_MX;
                end
            end
            SS_MX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = W_WIDE'(ax);
                o_cmd.b  = W_WIDE'(i_sums.cnt);
                o_cmd.k  = FRAC_Q16;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_MEAN_X, nx, q, i_rsp.big, ST_OK);
                    n_state = SS_MY;
                end
            end
            SS_MY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = W_WIDE'(ay);
                o_cmd.b  = W_WIDE'(i_sums.cnt);
                o_cmd.k  = FRAC_Q16;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_MEAN_Y, ny, q, i_rsp.big, ST_OK);
                    n_state = SS_VX;
                end
            end
            SS_VX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = r_dxx;
                o_cmd.b  = r_nn1;
                o_cmd.k  = FRAC_Q32;
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_vbig  = i_rsp.big;
                    n_state = SS_SDX;
                end
            end
            SS_SDX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_SQRT;
                o_cmd.a  = r_t1;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_SD_X, 1'b0, q, r_vbig, ST_OK);
                    n_state = SS_VY;
                end
            end
            SS_VY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = r_dyy;
                o_cmd.b  = r_nn1;
                o_cmd.k  = FRAC_Q32;
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_vbig  = i_rsp.big;
                    n_state = SS_SDY;
                end
            end
            SS_SDY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_SQRT;
                o_cmd.a  = r_t1;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_SD_Y, 1'b0, q, r_vbig, ST_OK);
                    n_state = SS_RCHK;
                end
            end
            // Correlation is undefined when either spread is zero
            SS_RCHK: begin
                if (r_dxxz || r_dyyz) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_CORR, 1'b0, '0, 1'b0, ST_UNDEF);
                    n_state = SS_LCHK;
                end else begin
                    n_state = SS_DXY2;
                end
            end
            SS_DXY2: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = r_dxy;
                o_cmd.b  = r_dxy;
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_state = SS_DXXYY;
                end
            end
            SS_DXXYY: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = r_dxx;
                o_cmd.b  = r_dyy;
                if (i_rsp.done) begin
                    n_t2    = i_rsp.res;
                    n_state = SS_R2;
                end
            end
            SS_R2: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = r_t1;
                o_cmd.b  = r_t2;
                o_cmd.k  = FRAC_Q32;
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_vbig  = i_rsp.big;
                    n_state = SS_R;
                end
            end
            SS_R: begin
                use_unit = 1'b1;
                o_cmd.op = UO_SQRT;
                o_cmd.a  = r_t1;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_CORR, r_dneg, q, r_vbig, ST_OK);
                    n_state = SS_LCHK;
                end
            end
            // Line is undefined when x has no spread
            SS_LCHK: begin
                if (r_dxxz) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_SLOPE, 1'b0, '0, 1'b0, ST_UNDEF);
                    n_state = SS_LUND;
                end else begin
                    n_state = SS_SL;
                end
            end
            SS_LUND: begin
                n_valid = 1'b1;
                n_out   = pss_put(K_INTERCEPT, 1'b0, '0, 1'b0, ST_UNDEF);
                o_clear = 1'b1;
                n_state = SS_IDLE;
            end
            SS_SL: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = r_dxy;
                o_cmd.b  = r_dxx;
                o_cmd.k  = FRAC_Q16;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_SLOPE, r_dneg && (q != '0), q, i_rsp.big, ST_OK);
                    n_state = SS_IA;
                end
            end
            SS_IA: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(ay);
                o_cmd.b  = r_dxx;
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_state = SS_IB;
                end
            end
            SS_IB: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(ax);
                o_cmd.b  = r_dxy;
                if (i_rsp.done) begin
                    n_t2    = i_rsp.res;
                    n_state = SS_INUM;
                end
            end
            // Intercept numerator Sy*Dxx - Sx*Dxy in sign-magnitude
            SS_INUM: begin
                use_unit = 1'b1;
                o_cmd.op = (ny != sb) ? UO_ADD : UO_DIFF;
                o_cmd.a  = r_t1;
                o_cmd.b  = r_t2;
                if (i_rsp.done) begin
                    n_t1    = i_rsp.res;
                    n_sn    = (ny != sb) ? ny : (ny ^ i_rsp.neg);
                    n_state = SS_NDXX;
                end
            end
            SS_NDXX: begin
                use_unit = 1'b1;
                o_cmd.op = UO_MUL;
                o_cmd.a  = W_WIDE'(i_sums.cnt);
                o_cmd.b  = r_dxx;
                if (i_rsp.done) begin
                    n_t2    = i_rsp.res;
                    n_state = SS_IC;
                end
            end
            SS_IC: begin
                use_unit = 1'b1;
                o_cmd.op = UO_DIV;
                o_cmd.a  = r_t1;
                o_cmd.b  = r_t2;
                o_cmd.k  = FRAC_Q16;
                if (i_rsp.done) begin
                    n_valid = 1'b1;
                    n_out   = pss_put(K_INTERCEPT, r_sn && ((q != '0) || i_rsp.big),
                                      q, i_rsp.big, ST_OK);
                    o_clear = 1'b1;
                    n_state = SS_IDLE;
                end
            end
            default: n_state = SS_IDLE;
        endcase
        // Issue once per step, then wait for the unit
        o_cmd.go = use_unit && !r_wait;
        if (o_cmd.go) begin
            n_wait = 1'b1;
        end
        if (i_rsp.done) begin
            n_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SS_IDLE;
            r_wait  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_t1   <= n_t1;
        r_t2   <= n_t2;
        r_nn1  <= n_nn1;
        r_dxx  <= n_dxx;
        r_dyy  <= n_dyy;
        r_dxy  <= n_dxy;
        r_dneg <= n_dneg;
        r_sn   <= n_sn;
        r_vbig <= n_vbig;
        r_dxxz <= n_dxxz;
        r_dyyz <= n_dyyz;
        r_out  <= n_out;
    end

    assign o_busy   = (r_state != SS_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SS_IDLE) |-> !r_wait)
        else $error("waiting on unit while idle");
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clear |=> (r_state == SS_IDLE) && r_valid && r_out.last_result)
        else $error("clear not paired with final result");
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp.done |-> r_wait)
        else $error("unit done without a request");

endmodule

>>> sv/paired_sample_statistics_top.sv
// Paired sample statistics with simple linear regression.
//
// Input: a word (x_sample, y_sample, last_pair) is taken on i_start while
// o_busy is low. Accumulating a pair has two steps: capture, then the
// three 16x16 products and the five sum updates, during which o_busy is
// high, so no new word is taken. Pairs past MAX_SAMPLES are dropped
// from the sums. After the last_pair word, o_busy stays high for the
// closing run: up to twelve 64-step multiplies, seven 144- or 160-step
// divides and three 32-step roots on one shared shift-add/subtract unit.
// Seven result words (mean x, mean y, sd x, sd y, correlation, slope,
// intercept) leave in that order, each on o_result for one cycle with
// o_valid high; last_result marks the seventh. With fewer than two pairs
// the seven words carry the too-few status and leave back to back.
// Results cannot be held off: the receiver must take each word
// in the cycle it is shown. Sums clear after the last word.
// Reset (synchronous, active low) clears the count and the sums and
// drops any run in progress.
module paired_sample_statistics_top
    import pss_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_pair   i_pair,
    output logic    o_busy,
    output logic    o_valid,
    output t_result o_result
);

    logic  take, acc_pend, acc_close, seq_busy, clear;
    t_sums sums;
    t_ucmd cmd;
    t_ursp rsp;

    assign take   = i_start & ~o_busy;
    assign o_busy = acc_pend | acc_close | seq_busy;

    pss_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_pair  (i_pair),
        .i_clear (clear),
        .o_sums  (sums),
        .o_pend  (acc_pend),
        .o_close (acc_close)
    );

    pss_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_rsp   (rsp)
    );

    pss_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_close  (acc_close),
        .i_sums   (sums),
        .i_rsp    (rsp),
        .o_cmd    (cmd),
        .o_clear  (clear),
        .o_busy   (seq_busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_last_then_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last_result) |=> !o_valid)
        else $error("result after the final word");
    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last_result) |-> o_busy)
        else $error("input open in the middle of a result run");
    a_close_idle_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_close |-> !seq_busy)
        else $error("new data set closed while a run is active");

endmodule
